/* src/tmt_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Trapezoid move timing package
// Shared widths, payload types and pipeline depths for the move timing block.
// ----------------------------------------------------------------------------
package tmt_pkg;

   localparam int unsigned FRACTION_BITS    = 16;
   localparam int unsigned WORD_BITS        = 32;
   localparam int unsigned PROD_BITS        = 2 * WORD_BITS;
   localparam int unsigned SQRT_STEPS       = WORD_BITS;
   localparam int unsigned DIV_STEPS        = WORD_BITS;
   localparam int unsigned DIV_LATENCY      = DIV_STEPS + 1;
   localparam int unsigned QUEUE_DEPTH      = 4;
   localparam int unsigned QUEUE_PTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int unsigned QUEUE_COUNT_BITS = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic signed [WORD_BITS-1:0] distance;
      logic [WORD_BITS-1:0]        cruise_speed;
      logic [WORD_BITS-1:0]        acceleration;
   } req_type;

   typedef struct packed {
      logic                 direction_negative;
      logic [WORD_BITS-1:0] ramp_time;
      logic [WORD_BITS-1:0] coast_time;
      logic [WORD_BITS-1:0] peak_speed;
      logic                 speed_error;
   } rsp_type;

   // A classified move as it travels from the front end to the back end.
   typedef struct packed {
      logic                 neg;
      logic                 err;
      logic                 cruise;
      logic [WORD_BITS-1:0] dist_mag;
      logic [WORD_BITS-1:0] speed;
      logic [WORD_BITS-1:0] accel;
      logic [PROD_BITS-1:0] dist_accel;
      logic [PROD_BITS-1:0] speed_sq;
   } work_type;

   // Fields that ride alongside the dividers.
   typedef struct packed {
      logic                 neg;
      logic                 err;
      logic                 cruise;
      logic [WORD_BITS-1:0] peak;
   } side_type;

endpackage : tmt_pkg
`default_nettype wire

/* src/tmt_queue.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Move queue
// Small register queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module tmt_queue
   import tmt_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     push,
   input  wire work_type push_data,
   output logic          full,
   input  wire logic     pop,
   output work_type      pop_data,
   output logic          empty
);

   work_type                    mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_COUNT_BITS-1:0] count_ff, count_in;
   logic                        do_push, do_pop;

   assign full     = (count_ff == QUEUE_COUNT_BITS'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule : tmt_queue
`default_nettype wire

/* src/tmt_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Move front end
// Takes moves, finds the magnitude and the special cases, forms the products.
// ----------------------------------------------------------------------------
module tmt_front
   import tmt_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_push,
   input  wire req_type req_data,
   output logic         req_full,
   output logic         q_push,
   output work_type     q_data,
   input  wire logic    q_full
);

   logic                 en;
   logic                 a_valid_ff, b_valid_ff;
   logic                 a_neg_ff, a_err_ff, a_cruise_ff;
   logic [WORD_BITS-1:0] a_dist_ff, a_speed_ff, a_accel_ff;
   logic [WORD_BITS-1:0] dist_in;
   work_type             b_work_ff;

   assign en       = !q_full;
   assign req_full = !en;
   assign q_push   = en && b_valid_ff;
   assign q_data   = b_work_ff;

   // The magnitude of the most negative distance wraps to 2^31, which is exact.
   assign dist_in = req_data.distance[WORD_BITS-1] ? (WORD_BITS'(0) - req_data.distance)
                                                    : req_data.distance;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else if (en) begin
         a_valid_ff <= req_push;
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_neg_ff    <= req_data.distance[WORD_BITS-1];
         a_err_ff    <= (req_data.cruise_speed == '0);
         a_cruise_ff <= (req_data.acceleration == '0) || (req_data.distance == '0);
         a_dist_ff   <= dist_in;
         a_speed_ff  <= req_data.cruise_speed;
         a_accel_ff  <= req_data.acceleration;

         b_work_ff.neg        <= a_neg_ff;
         b_work_ff.err        <= a_err_ff;
         b_work_ff.cruise     <= a_cruise_ff;
         b_work_ff.dist_mag   <= a_dist_ff;
         b_work_ff.speed      <= a_speed_ff;
         b_work_ff.accel      <= a_accel_ff;
         b_work_ff.dist_accel <= PROD_BITS'(a_dist_ff) * PROD_BITS'(a_accel_ff);
         b_work_ff.speed_sq   <= PROD_BITS'(a_speed_ff) * PROD_BITS'(a_speed_ff);
      end
   end

endmodule : tmt_front
`default_nettype wire

/* src/tmt_sqrt.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Pipelined square root
// Floor square root of a 64-bit value, one result bit per stage.
// ----------------------------------------------------------------------------
module tmt_sqrt
   import tmt_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 en,
   input  wire logic [PROD_BITS-1:0] radicand,
   output logic [WORD_BITS-1:0]      root
);

   logic [PROD_BITS-1:0] x_ff   [SQRT_STEPS];
   logic [PROD_BITS-1:0] res_ff [SQRT_STEPS];

   for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
      localparam logic [PROD_BITS-1:0] STEP_BIT = PROD_BITS'(1) << (PROD_BITS - 2 - 2 * k);
      logic [PROD_BITS-1:0] x_src, res_src, trial, x_in, res_in;
      logic                 ge;

      if (k == 0) begin : g_first
         assign x_src   = radicand;
         assign res_src = '0;
      end else begin : g_next
         assign x_src   = x_ff[k-1];
         assign res_src = res_ff[k-1];
      end

      assign trial  = res_src + STEP_BIT;
      assign ge     = (x_src >= trial);
      assign x_in   = ge ? (x_src - trial) : x_src;
      assign res_in = ge ? ((res_src >> 1) + STEP_BIT) : (res_src >> 1);

      always_ff @(posedge clock) begin
         if (en) begin
            x_ff[k]   <= x_in;
            res_ff[k] <= res_in;
         end
      end
   end

   assign root = res_ff[SQRT_STEPS-1][WORD_BITS-1:0];

endmodule : tmt_sqrt
`default_nettype wire

/* src/tmt_div.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Pipelined fixed-point divider
// Floor of (num * 2^FRACTION_BITS) / den, saturated to 32 bits.
// ----------------------------------------------------------------------------
module tmt_div
   import tmt_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 en,
   input  wire logic [PROD_BITS-1:0] num,
   input  wire logic [PROD_BITS-1:0] den,
   output logic [WORD_BITS-1:0]      quot
);

   logic [PROD_BITS-1:0] rem_ff  [DIV_LATENCY];
   logic [PROD_BITS-1:0] den_ff  [DIV_LATENCY];
   logic [WORD_BITS-1:0] low_ff  [DIV_LATENCY];
   logic [WORD_BITS-1:0] q_ff    [DIV_LATENCY];
   logic                 sat_ff  [DIV_LATENCY];
   logic [PROD_BITS-1:0] high_in;

   // The scaled dividend's upper part already below den means the quotient fits.
   assign high_in = num >> (WORD_BITS - FRACTION_BITS);

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= high_in;
         den_ff[0] <= den;
         low_ff[0] <= WORD_BITS'(num << FRACTION_BITS);
         q_ff[0]   <= '0;
         sat_ff[0] <= (high_in >= den);
      end
   end

   for (genvar j = 1; j < DIV_LATENCY; j++) begin : g_step
      logic [PROD_BITS:0]   trial;
      logic                 ge;
      logic [PROD_BITS-1:0] rem_in;

      assign trial  = {rem_ff[j-1], low_ff[j-1][WORD_BITS-1]};
      assign ge     = (trial >= {1'b0, den_ff[j-1]});
      assign rem_in = ge ? PROD_BITS'(trial - {1'b0, den_ff[j-1]}) : PROD_BITS'(trial);

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[j] <= rem_in;
            den_ff[j] <= den_ff[j-1];
            low_ff[j] <= low_ff[j-1] << 1;
            q_ff[j]   <= {q_ff[j-1][WORD_BITS-2:0], ge};
            sat_ff[j] <= sat_ff[j-1];
         end
      end
   end

   assign quot = sat_ff[DIV_LATENCY-1] ? '1 : q_ff[DIV_LATENCY-1];

endmodule : tmt_div
`default_nettype wire

/* src/tmt_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Move back end
// Square root, products and the two dividers, then the result queue.
// ----------------------------------------------------------------------------
module tmt_back
   import tmt_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   output logic          q_pop,
   input  wire work_type q_data,
   input  wire logic     q_empty,
   output logic          rsp_empty,
   input  wire logic     rsp_pop,
   output rsp_type       rsp_data
);

   logic                 en;
   logic                 c_valid_ff, c_use_sqrt_ff;
   work_type             c_work_ff;
   logic                 sq_valid_ff [SQRT_STEPS];
   logic                 sq_use_ff   [SQRT_STEPS];
   work_type             sq_work_ff  [SQRT_STEPS];
   logic [WORD_BITS-1:0] root;

   logic                 m_valid_ff;
   work_type             m_work_ff;
   logic [WORD_BITS-1:0] m_peak_ff;
   logic [PROD_BITS-1:0] m_peak_sq_ff, m_accel_peak_ff;
   logic [WORD_BITS-1:0] peak_in;

   logic                 p_valid_ff;
   side_type             p_side_ff;
   logic [PROD_BITS-1:0] p_ramp_num_ff, p_ramp_den_ff, p_coast_num_ff, p_coast_den_ff;

   logic                 dv_valid_ff [DIV_LATENCY];
   side_type             dv_side_ff  [DIV_LATENCY];
   logic [WORD_BITS-1:0] ramp_quot, coast_quot;

   rsp_type                     out_in;
   logic                        out_push, out_pop;
   rsp_type                     out_mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0]   out_wr_ff, out_rd_ff;
   logic [QUEUE_COUNT_BITS-1:0] out_count_ff, out_count_in;

   // The whole pipeline advances together while the result queue has room.
   assign en    = (out_count_ff != QUEUE_COUNT_BITS'(QUEUE_DEPTH));
   assign q_pop = en && !q_empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
         m_valid_ff <= 1'b0;
         p_valid_ff <= 1'b0;
      end else if (en) begin
         c_valid_ff <= q_pop;
         m_valid_ff <= sq_valid_ff[SQRT_STEPS-1];
         p_valid_ff <= m_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         c_work_ff     <= q_data;
         c_use_sqrt_ff <= (q_data.dist_accel < q_data.speed_sq);
      end
   end

   tmt_sqrt u_sqrt (
      .clock    (clock),
      .en       (en),
      .radicand (c_work_ff.dist_accel),
      .root     (root)
   );

   for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sq_side
      if (k == 0) begin : g_first
         always_ff @(posedge clock) begin
            if (reset) begin
               sq_valid_ff[k] <= 1'b0;
            end else if (en) begin
               sq_valid_ff[k] <= c_valid_ff;
            end
         end
         always_ff @(posedge clock) begin
            if (en) begin
               sq_work_ff[k] <= c_work_ff;
               sq_use_ff[k]  <= c_use_sqrt_ff;
            end
         end
      end else begin : g_next
         always_ff @(posedge clock) begin
            if (reset) begin
               sq_valid_ff[k] <= 1'b0;
            end else if (en) begin
               sq_valid_ff[k] <= sq_valid_ff[k-1];
            end
         end
         always_ff @(posedge clock) begin
            if (en) begin
               sq_work_ff[k] <= sq_work_ff[k-1];
               sq_use_ff[k]  <= sq_use_ff[k-1];
            end
         end
      end
   end

   // A move too short to reach cruise speed peaks at sqrt(distance * acceleration).
   assign peak_in = sq_use_ff[SQRT_STEPS-1] ? root : sq_work_ff[SQRT_STEPS-1].speed;

   always_ff @(posedge clock) begin
      if (en) begin
         m_work_ff       <= sq_work_ff[SQRT_STEPS-1];
         m_peak_ff       <= peak_in;
         m_peak_sq_ff    <= PROD_BITS'(peak_in) * PROD_BITS'(peak_in);
         m_accel_peak_ff <= PROD_BITS'(sq_work_ff[SQRT_STEPS-1].accel) * PROD_BITS'(peak_in);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p_side_ff.neg    <= m_work_ff.neg;
         p_side_ff.err    <= m_work_ff.err;
         p_side_ff.cruise <= m_work_ff.cruise;
         p_side_ff.peak   <= m_work_ff.cruise ? m_work_ff.speed : m_peak_ff;
         p_ramp_num_ff    <= PROD_BITS'(m_peak_ff);
         p_ramp_den_ff    <= PROD_BITS'(m_work_ff.accel);
         if (m_work_ff.cruise) begin
            p_coast_num_ff <= PROD_BITS'(m_work_ff.dist_mag);
            p_coast_den_ff <= PROD_BITS'(m_work_ff.speed);
         end else begin
            p_coast_num_ff <= m_work_ff.dist_accel - m_peak_sq_ff;
            p_coast_den_ff <= m_accel_peak_ff;
         end
      end
   end

   tmt_div u_ramp_div (
      .clock (clock),
      .en    (en),
      .num   (p_ramp_num_ff),
      .den   (p_ramp_den_ff),
      .quot  (ramp_quot)
   );

   tmt_div u_coast_div (
      .clock (clock),
      .en    (en),
      .num   (p_coast_num_ff),
      .den   (p_coast_den_ff),
      .quot  (coast_quot)
   );

   for (genvar j = 0; j < DIV_LATENCY; j++) begin : g_dv_side
      if (j == 0) begin : g_first
         always_ff @(posedge clock) begin
            if (reset) begin
               dv_valid_ff[j] <= 1'b0;
            end else if (en) begin
               dv_valid_ff[j] <= p_valid_ff;
            end
         end
         always_ff @(posedge clock) begin
            if (en) begin
               dv_side_ff[j] <= p_side_ff;
            end
         end
      end else begin : g_next
         always_ff @(posedge clock) begin
            if (reset) begin
               dv_valid_ff[j] <= 1'b0;
            end else if (en) begin
               dv_valid_ff[j] <= dv_valid_ff[j-1];
            end
         end
         always_ff @(posedge clock) begin
            if (en) begin
               dv_side_ff[j] <= dv_side_ff[j-1];
            end
         end
      end
   end

   always_comb begin
      out_in.direction_negative = dv_side_ff[DIV_LATENCY-1].neg;
      out_in.speed_error        = 1'b0;
      out_in.ramp_time          = ramp_quot;
      out_in.coast_time         = coast_quot;
      out_in.peak_speed         = dv_side_ff[DIV_LATENCY-1].peak;
      priority if (dv_side_ff[DIV_LATENCY-1].err) begin
         out_in.speed_error = 1'b1;
         out_in.ramp_time   = '0;
         out_in.coast_time  = '0;
         out_in.peak_speed  = '0;
      end else if (dv_side_ff[DIV_LATENCY-1].cruise) begin
         out_in.ramp_time = '0;
      end
   end

   assign out_push  = en && dv_valid_ff[DIV_LATENCY-1];
   assign rsp_empty = (out_count_ff == '0);
   assign out_pop   = rsp_pop && !rsp_empty;
   assign rsp_data  = out_mem_ff[out_rd_ff];

   always_comb begin
      out_count_in = out_count_ff;
      if (out_push && !out_pop) begin
         out_count_in = out_count_ff + 1'b1;
      end else if (out_pop && !out_push) begin
         out_count_in = out_count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_wr_ff    <= '0;
         out_rd_ff    <= '0;
         out_count_ff <= '0;
      end else begin
         if (out_push) begin
            out_wr_ff <= out_wr_ff + 1'b1;
         end
         if (out_pop) begin
            out_rd_ff <= out_rd_ff + 1'b1;
         end
         out_count_ff <= out_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_push) begin
         out_mem_ff[out_wr_ff] <= out_in;
      end
   end

`ifndef ASSERT_OFF
   a_out_count_bound: assert property (@(posedge clock) disable iff (reset)
      out_count_ff <= QUEUE_COUNT_BITS'(QUEUE_DEPTH))
      else $error("result queue count above its depth");

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      out_push |-> (out_count_ff != QUEUE_COUNT_BITS'(QUEUE_DEPTH)))
      else $error("result written into a full queue");

   a_stall_holds_tail: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(dv_valid_ff[DIV_LATENCY-1]))
      else $error("pipeline moved while stalled");

   a_pop_only_when_stage_moves: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> c_valid_ff)
      else $error("popped move not captured");
`endif

endmodule : tmt_back
`default_nettype wire

/* src/trapezoid_move_timing_top.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Trapezoid move timing
// Ramp time, coast time and peak speed of a symmetric trapezoidal move.
// ----------------------------------------------------------------------------
// Usage:
//   Moves enter on the req_ channel: a transfer happens at a clock edge with
//   req_push high and req_full low. Results leave on the rsp_ channel in the
//   same order: the oldest result is on rsp_data while rsp_empty is low, and
//   a transfer happens at an edge with rsp_pop high and rsp_empty low.
//   One move is taken every cycle while req_full is low, and each move gives
//   exactly one result. A move passes through two front-end stages, the move
//   queue, a compare stage, a 32-stage square root, two product stages and
//   two 33-stage dividers working side by side.
//   The back end advances as one pipeline while its four-entry result queue
//   has room; when the receiver stops popping, the back end holds, the move
//   queue fills and then req_full rises until space frees up.
//   A synchronous reset empties both queues and all pipeline stages.
// ----------------------------------------------------------------------------
module trapezoid_move_timing_top
   import tmt_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_push,
   input  wire req_type req_data,
   output logic         req_full,
   input  wire logic    rsp_pop,
   output rsp_type      rsp_data,
   output logic         rsp_empty
);

   logic     fq_push, fq_full, fq_pop, fq_empty;
   work_type fq_push_data, fq_pop_data;

   tmt_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_data (req_data),
      .req_full (req_full),
      .q_push   (fq_push),
      .q_data   (fq_push_data),
      .q_full   (fq_full)
   );

   tmt_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (fq_push),
      .push_data (fq_push_data),
      .full      (fq_full),
      .pop       (fq_pop),
      .pop_data  (fq_pop_data),
      .empty     (fq_empty)
   );

   tmt_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_pop     (fq_pop),
      .q_data    (fq_pop_data),
      .q_empty   (fq_empty),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule : trapezoid_move_timing_top
`default_nettype wire

/* dv/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Trapezoid move timing testbench
// Drives moves through the queue-style ports with random idling, predicts
// each move's timing in fixed point and checks results in order.
// ----------------------------------------------------------------------------
module tb_top;
   import tmt_pkg::*;

   localparam int LATENCY   = 71;
   localparam int WDOG_MAX  = 20000;
   localparam int N_RANDOM  = 1400;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_push = 1'b0;
   req_type req_data = '0;
   logic    req_full;
   logic    rsp_pop = 1'b0;
   rsp_type rsp_data;
   logic    rsp_empty;

   int  fail_count = 0;
   int  idle_cycles = 0;
   bit  sender_done = 1'b0;
   bit  hold_receiver = 1'b0;
   bit  no_idle = 1'b0;

   trapezoid_move_timing_top dut (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_data(req_data), .req_full(req_full),
      .rsp_pop(rsp_pop), .rsp_data(rsp_data), .rsp_empty(rsp_empty)
   );

   always #6 clock = ~clock;

   // Predicted move timing and in-order store of expected results.
   class move_timing_board;
      rsp_type pending[$];

      function automatic logic [63:0] root_floor(logic [63:0] x);
         logic [63:0] res;
         logic [63:0] bitv;
         res = 0;
         bitv = 64'd1 << 62;
         while (bitv > x) bitv = bitv >> 2;
         while (bitv != 0) begin
            if (x >= res + bitv) begin
               x = x - (res + bitv);
               res = (res >> 1) + bitv;
            end else begin
               res = res >> 1;
            end
            bitv = bitv >> 2;
         end
         return res;
      endfunction

      function automatic logic [31:0] fixed_quotient(logic [63:0] num, logic [63:0] den);
         logic [127:0] q;
         q = ({64'd0, num} << FRACTION_BITS) / {64'd0, den};
         if (q > 128'hFFFF_FFFF) return 32'hFFFF_FFFF;
         return q[31:0];
      endfunction

      function void note_move(req_type m);
         rsp_type     r;
         logic [63:0] d, s, a, da, ss, v;
         r = '0;
         r.direction_negative = m.distance[31];
         d = m.distance[31] ? {32'd0, -m.distance} : {32'd0, m.distance};
         if (m.distance == 32'sh8000_0000) d = 64'd1 << 31;
         s = {32'd0, m.cruise_speed};
         a = {32'd0, m.acceleration};
         if (s == 0) begin
            r.speed_error = 1'b1;
         end else if (a == 0 || d == 0) begin
            r.coast_time = fixed_quotient(d, s);
            r.peak_speed = s[31:0];
         end else begin
            da = d * a;
            ss = s * s;
            v = (da < ss) ? root_floor(da) : s;
            r.ramp_time  = fixed_quotient(v, a);
            r.coast_time = fixed_quotient(da - v * v, a * v);
            r.peak_speed = v[31:0];
         end
         pending.push_back(r);
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         if (pending.size() == 0) begin
            $display("%0t: unexpected result %h", $time, got);
            fail_count++;
            return;
         end
         want = pending.pop_front();
         if (got.direction_negative !== want.direction_negative)
            report("direction_negative", want.direction_negative, got.direction_negative);
         if (got.ramp_time !== want.ramp_time)
            report("ramp_time", want.ramp_time, got.ramp_time);
         if (got.coast_time !== want.coast_time)
            report("coast_time", want.coast_time, got.coast_time);
         if (got.peak_speed !== want.peak_speed)
            report("peak_speed", want.peak_speed, got.peak_speed);
         if (got.speed_error !== want.speed_error)
            report("speed_error", want.speed_error, got.speed_error);
      endfunction

      function void report(string field, logic [31:0] want, logic [31:0] got);
         $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
         fail_count++;
      endfunction
   endclass

   move_timing_board board = new();

   // Sampling at the rising edge: both transfers are decided here.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_push && !req_full) begin
            board.note_move(req_data);
         end
         if (rsp_pop && !rsp_empty) begin
            board.check_result(rsp_data);
         end
         // An offered move that is never taken counts as idle too.
         if ((req_push && !req_full) || (rsp_pop && !rsp_empty) ||
             (board.pending.size() == 0 && !req_push))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= WDOG_MAX) begin
            $display("FAIL trapezoid_move_timing_top");
            $finish;
         end
      end
   end

   // Receiver: random stall bursts, plus one long hold on request.
   initial begin : receiver
      int gap;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_receiver) begin
            rsp_pop <= 1'b0;
            repeat (300) @(negedge clock);
            hold_receiver = 1'b0;
         end else if (!no_idle && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 8);
            rsp_pop <= 1'b0;
            repeat (gap) @(negedge clock);
         end else begin
            rsp_pop <= 1'b1;
            @(negedge clock);
         end
      end
   end

   // Drives one move and holds it until the transfer happens.
   task automatic send_move(req_type m);
      int gap;
      if (!no_idle && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 8);
         req_push <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_push <= 1'b1;
      req_data <= m;
      do @(posedge clock); while (req_full);
      @(negedge clock);
   endtask

   task automatic send_fields(logic [31:0] d, logic [31:0] s, logic [31:0] a);
      req_type m;
      m.distance = d;
      m.cruise_speed = s;
      m.acceleration = a;
      send_move(m);
   endtask

   function automatic logic [31:0] any_word();
      case ($urandom_range(0, 5))
         0: return $urandom_range(0, 3);
         1: return 32'hFFFF_FFFF - $urandom_range(0, 3);
         2: return $urandom >> $urandom_range(0, 31);
         default: return $urandom;
      endcase
   endfunction

   task automatic drain_all();
      req_push <= 1'b0;
      while (board.pending.size() != 0) @(negedge clock);
   endtask

   initial begin : sender
      logic [31:0] d, s, a;
      repeat (7) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: extremes, zero speed, pure cruise, short moves.
      send_fields(32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
      send_fields(32'h8000_0000, 32'h0010_0000, 32'h0002_0000);
      send_fields(32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_fields(32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_fields(32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_0001);
      send_fields(32'h0005_0000, 32'h0000_0000, 32'h0001_0000);
      send_fields(32'hFFFB_0000, 32'h0000_0000, 32'h0000_0000);
      send_fields(32'h0000_0000, 32'h0003_0000, 32'h0001_0000);
      send_fields(32'hFFF0_0000, 32'h0002_0000, 32'h0000_0000);
      send_fields(32'h7FFF_FFFF, 32'h0000_0001, 32'h0000_0000);
      send_fields(32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0001);
      send_fields(32'h0000_1000, 32'h0100_0000, 32'h0001_0000);
      send_fields(32'h0100_0000, 32'h0001_0000, 32'h0000_0001);
      send_fields(32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF);
      send_fields(32'h8000_0000, 32'h0000_0001, 32'h0000_0000);

      // The sender pauses until every expected result has come.
      drain_all();

      for (int i = 0; i < N_RANDOM; i++) begin
         if (i == 300) hold_receiver = 1'b1;
         if (i == N_RANDOM - 200) no_idle = 1'b1;
         d = any_word();
         s = ($urandom_range(0, 15) == 0) ? 32'd0 : any_word();
         a = ($urandom_range(0, 15) == 0) ? 32'd0 : any_word();
         if ($urandom_range(0, 15) == 0) d = 32'd0;
         send_fields(d, s, a);
      end
      drain_all();
      sender_done = 1'b1;
   end

   initial begin : finisher
      wait (sender_done);
      repeat (LATENCY + 10) @(posedge clock);
      if (fail_count == 0 && board.pending.size() == 0) begin
         $display("PASS trapezoid_move_timing_top");
      end else begin
         $display("FAIL trapezoid_move_timing_top");
      end
      $finish;
   end

endmodule
